// ===== src/erc_pkg.sv =====
// shared types, codes and constant tables for the euler rotation converter
// no dependencies; used by euler_rotation_convert
package erc_pkg;

  typedef enum logic {
    OP_TO_ANGLES = 1'b0,
    OP_TO_MATRIX = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // atan(2^-i) in units of 2^-32 circle, truncated
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // cordic inverse gain in q30
  localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;

  // micro-rotation angle rescaled to a w-bit circle
  function automatic logic [63:0] atan_step(input int i, input int w);
    logic [63:0] t;
    int sh;
    if (i >= 32) begin
      return 64'd0;
    end
    t = {32'd0, ATAN_TAB[i[4:0]]};
    if (w >= 32) begin
      return t << (w - 32);
    end
    sh = 32 - w;
    return (t + (64'd1 << (sh - 1))) >> sh;
  endfunction

  // inverse gain rescaled to f fraction bits
  function automatic logic [63:0] inv_gain(input int f);
    int sh;
    if (f >= 30) begin
      return INV_GAIN_Q30 << (f - 30);
    end
    sh = 30 - f;
    return (INV_GAIN_Q30 + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== src/euler_rotation_convert.sv =====
// throughput: one word per cycle unless the result side stalls; the path is
// vectoring cordic, rotation cordic, two multiply stages, a sum stage, a second
// vectoring cordic and the output register
// a stall on the result side freezes every stage and holds the input side stalled
// reset clears the stage valid bits only; data registers are not reset
// depends on erc_pkg
module euler_rotation_convert #(
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 30
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         stall,
  input  logic                         op,
  input  logic signed [DATA_WIDTH-1:0] value_0,
  input  logic signed [DATA_WIDTH-1:0] value_1,
  input  logic signed [DATA_WIDTH-1:0] value_2,
  input  logic signed [DATA_WIDTH-1:0] value_3,
  input  logic signed [DATA_WIDTH-1:0] value_4,
  input  logic signed [DATA_WIDTH-1:0] value_5,
  input  logic signed [DATA_WIDTH-1:0] value_6,
  input  logic signed [DATA_WIDTH-1:0] value_7,
  input  logic signed [DATA_WIDTH-1:0] value_8,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [DATA_WIDTH-1:0] result_0,
  output logic signed [DATA_WIDTH-1:0] result_1,
  output logic signed [DATA_WIDTH-1:0] result_2,
  output logic signed [DATA_WIDTH-1:0] result_3,
  output logic signed [DATA_WIDTH-1:0] result_4,
  output logic signed [DATA_WIDTH-1:0] result_5,
  output logic signed [DATA_WIDTH-1:0] result_6,
  output logic signed [DATA_WIDTH-1:0] result_7,
  output logic signed [DATA_WIDTH-1:0] result_8
);

  localparam int W   = DATA_WIDTH;
  localparam int N   = CORDIC_STAGES;
  localparam int F   = W - 2;
  localparam int K   = $clog2(W);
  localparam int VW  = W + 3;
  localparam int RW  = W + 1;
  localparam int PW  = W + 2;
  localparam int NV  = K + 1 + N;
  localparam int NR  = N + 1;
  localparam int LAT = NV + NR + 3 + NV + 1;

  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [RW-1:0] INVG = RW'(erc_pkg::inv_gain(F));
  localparam logic signed [PW:0] SMAX = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW:0] SMIN = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    erc_pkg::op_t        op;
    logic [6:0][W-1:0]   e;
  } sba_t;

  typedef struct packed {
    erc_pkg::op_t        op;
    logic [6:0][W-1:0]   e;
    logic [W-1:0]        yaw;
  } sbb_t;

  typedef struct packed {
    erc_pkg::op_t        op;
    logic [8:0][W-1:0]   r;
  } sbc_t;

  function automatic logic signed [PW-1:0] mulq(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    logic [PW-1:0]   ua;
    logic [PW-1:0]   ub;
    logic [2*PW-1:0] p;
    logic [PW-1:0]   r;
    ua = a[PW-1] ? PW'(-a) : PW'(a);
    ub = b[PW-1] ? PW'(-b) : PW'(b);
    p  = (2*PW)'(ua) * (2*PW)'(ub) + ((2*PW)'(1) << (F - 1));
    r  = PW'(p >> F);
    return (a[PW-1] ^ b[PW-1]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [W-1:0] sat(input logic signed [PW:0] v);
    if (v > SMAX) begin
      return {1'b0, {(W-1){1'b1}}};
    end
    if (v < SMIN) begin
      return {1'b1, {(W-1){1'b0}}};
    end
    return v[W-1:0];
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  assign result_valid = vld[LAT-1];
  assign en           = !(result_valid && result_stall);
  assign stall        = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], valid};
    end
  end

  // vectoring cordic units: yaw, pitch, roll
  logic signed [VW-1:0] vsx [3];
  logic signed [VW-1:0] vsy [3];
  logic [W-1:0]         vang [3];

  for (genvar u = 0; u < 3; u++) begin : g_vec
    logic signed [VW-1:0] nx [K];
    logic signed [VW-1:0] ny [K];
    logic signed [VW-1:0] cx [N+1];
    logic signed [VW-1:0] cy [N+1];
    logic [W-1:0]         cz [N+1];
    logic                 czero [N+1];

    // normalize so the larger magnitude reaches half scale
    for (genvar j = 0; j < K; j++) begin : g_norm
      localparam int SH = 1 << (K - 1 - j);
      logic signed [VW-1:0] sx;
      logic signed [VW-1:0] sy;
      logic [VW-1:0]        ax;
      logic [VW-1:0]        ay;
      logic [VW-1:0]        mag;
      if (j == 0) begin : g_first
        assign sx = vsx[u];
        assign sy = vsy[u];
      end else begin : g_next
        assign sx = nx[j-1];
        assign sy = ny[j-1];
      end
      assign ax  = sx[VW-1] ? VW'(-sx) : VW'(sx);
      assign ay  = sy[VW-1] ? VW'(-sy) : VW'(sy);
      assign mag = ax | ay;
      always_ff @(posedge clk) begin
        if (en) begin
          if (mag[VW-1:W-SH] == '0) begin
            nx[j] <= sx <<< SH;
            ny[j] <= sy <<< SH;
          end else begin
            nx[j] <= sx;
            ny[j] <= sy;
          end
        end
      end
    end

    // fold the left half plane onto the right
    always_ff @(posedge clk) begin
      if (en) begin
        czero[0] <= (nx[K-1] == '0) && (ny[K-1] == '0);
        if (nx[K-1][VW-1]) begin
          cx[0] <= -nx[K-1];
          cy[0] <= -ny[K-1];
          cz[0] <= HALF;
        end else begin
          cx[0] <= nx[K-1];
          cy[0] <= ny[K-1];
          cz[0] <= '0;
        end
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic [W-1:0] AT = W'(erc_pkg::atan_step(i, W));
      always_ff @(posedge clk) begin
        if (en) begin
          czero[i+1] <= czero[i];
          if (!cy[i][VW-1]) begin
            cx[i+1] <= cx[i] + (cy[i] >>> i);
            cy[i+1] <= cy[i] - (cx[i] >>> i);
            cz[i+1] <= cz[i] + AT;
          end else begin
            cx[i+1] <= cx[i] - (cy[i] >>> i);
            cy[i+1] <= cy[i] + (cx[i] >>> i);
            cz[i+1] <= cz[i] - AT;
          end
        end
      end
    end

    assign vang[u] = czero[N] ? '0 : cz[N];
  end

  // stage group one: yaw from the first column
  sba_t sba [NV];

  assign vsx[0] = VW'(value_0);
  assign vsy[0] = VW'(value_3);

  always_ff @(posedge clk) begin
    if (en) begin
      sba[0].op <= erc_pkg::op_t'(op);
      sba[0].e  <= {value_6, value_5, value_4, value_3, value_2, value_1, value_0};
      for (int k = 1; k < NV; k++) begin
        sba[k] <= sba[k-1];
      end
    end
  end

  // rotation cordic units: sin and cos of three angles
  logic [W-1:0]         rsrc [3];
  logic signed [RW-1:0] rc [3];
  logic signed [RW-1:0] rs [3];

  assign rsrc[0] = (sba[NV-1].op == erc_pkg::OP_TO_MATRIX) ? sba[NV-1].e[0] : vang[0];
  assign rsrc[1] = sba[NV-1].e[1];
  assign rsrc[2] = sba[NV-1].e[2];

  for (genvar r = 0; r < 3; r++) begin : g_rot
    logic signed [RW-1:0] rx [N];
    logic signed [RW-1:0] ry [N];
    logic signed [W-1:0]  rz [N];
    logic [1:0]           rq [N];

    for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [W-1:0] AT = W'(erc_pkg::atan_step(i, W));
      logic signed [RW-1:0] px;
      logic signed [RW-1:0] py;
      logic signed [W-1:0]  pz;
      logic [1:0]           pq;
      if (i == 0) begin : g_first
        assign px = INVG;
        assign py = '0;
        assign pz = $signed({2'b00, rsrc[r][W-3:0]});
        assign pq = rsrc[r][W-1:W-2];
      end else begin : g_next
        assign px = rx[i-1];
        assign py = ry[i-1];
        assign pz = rz[i-1];
        assign pq = rq[i-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rq[i] <= pq;
          if (!pz[W-1]) begin
            rx[i] <= px - (py >>> i);
            ry[i] <= py + (px >>> i);
            rz[i] <= pz - AT;
          end else begin
            rx[i] <= px + (py >>> i);
            ry[i] <= py - (px >>> i);
            rz[i] <= pz + AT;
          end
        end
      end
    end

    // quadrant applied exactly
    always_ff @(posedge clk) begin
      if (en) begin
        unique case (erc_pkg::quad_t'(rq[N-1]))
          erc_pkg::QUAD_1: begin
            rc[r] <= -ry[N-1];
            rs[r] <= rx[N-1];
          end
          erc_pkg::QUAD_2: begin
            rc[r] <= -rx[N-1];
            rs[r] <= -ry[N-1];
          end
          erc_pkg::QUAD_3: begin
            rc[r] <= ry[N-1];
            rs[r] <= -rx[N-1];
          end
          default: begin
            rc[r] <= rx[N-1];
            rs[r] <= ry[N-1];
          end
        endcase
      end
    end
  end

  sbb_t sbb [NR];

  always_ff @(posedge clk) begin
    if (en) begin
      sbb[0].op  <= sba[NV-1].op;
      sbb[0].e   <= sba[NV-1].e;
      sbb[0].yaw <= vang[0];
      for (int k = 1; k < NR; k++) begin
        sbb[k] <= sbb[k-1];
      end
    end
  end

  // first product stage
  logic signed [PW-1:0] ma [10];
  logic signed [PW-1:0] mb [10];
  logic signed [PW-1:0] sa_p, ca_p, sb_p, cb_p, sg_p, cg_p;
  logic signed [PW-1:0] ep [7];

  assign sa_p = PW'(rs[0]);
  assign ca_p = PW'(rc[0]);
  assign sb_p = PW'(rs[1]);
  assign cb_p = PW'(rc[1]);
  assign sg_p = PW'(rs[2]);
  assign cg_p = PW'(rc[2]);

  for (genvar k = 0; k < 7; k++) begin : g_ep
    assign ep[k] = PW'($signed(sbb[NR-1].e[k]));
  end

  always_comb begin
    if (sbb[NR-1].op == erc_pkg::OP_TO_MATRIX) begin
      ma[0] = cb_p; mb[0] = cg_p;
      ma[1] = cg_p; mb[1] = sa_p;
      ma[2] = ca_p; mb[2] = sg_p;
      ma[3] = sa_p; mb[3] = sg_p;
      ma[4] = ca_p; mb[4] = cg_p;
      ma[5] = cb_p; mb[5] = sg_p;
      ma[6] = sa_p; mb[6] = sb_p;
      ma[7] = ca_p; mb[7] = sb_p;
      ma[8] = cb_p; mb[8] = sa_p;
      ma[9] = ca_p; mb[9] = cb_p;
    end else begin
      ma[0] = ep[0]; mb[0] = ca_p;
      ma[1] = ep[3]; mb[1] = sa_p;
      ma[2] = ep[2]; mb[2] = sa_p;
      ma[3] = ep[5]; mb[3] = ca_p;
      ma[4] = ep[4]; mb[4] = ca_p;
      ma[5] = ep[1]; mb[5] = sa_p;
      ma[6] = '0;    mb[6] = '0;
      ma[7] = '0;    mb[7] = '0;
      ma[8] = '0;    mb[8] = '0;
      ma[9] = '0;    mb[9] = '0;
    end
  end

  erc_pkg::op_t         m1_op;
  logic [W-1:0]         m1_yaw;
  logic signed [VW-1:0] m1_ne6;
  logic signed [PW-1:0] m1_sb;
  logic signed [PW-1:0] m1_sg;
  logic signed [PW-1:0] m1_p [10];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_op  <= sbb[NR-1].op;
      m1_yaw <= sbb[NR-1].yaw;
      m1_ne6 <= -VW'($signed(sbb[NR-1].e[6]));
      m1_sb  <= sb_p;
      m1_sg  <= sg_p;
      for (int k = 0; k < 10; k++) begin
        m1_p[k] <= mulq(ma[k], mb[k]);
      end
    end
  end

  // second product stage
  erc_pkg::op_t         m2_op;
  logic [W-1:0]         m2_yaw;
  logic signed [VW-1:0] m2_ne6;
  logic signed [PW-1:0] m2_sb;
  logic signed [PW-1:0] m2_p [10];
  logic signed [PW-1:0] m2_t [4];

  always_ff @(posedge clk) begin
    if (en) begin
      m2_op   <= m1_op;
      m2_yaw  <= m1_yaw;
      m2_ne6  <= m1_ne6;
      m2_sb   <= m1_sb;
      m2_p    <= m1_p;
      m2_t[0] <= mulq(m1_p[1], m1_sb);
      m2_t[1] <= mulq(m1_p[4], m1_sb);
      m2_t[2] <= mulq(m1_p[6], m1_sg);
      m2_t[3] <= mulq(m1_p[7], m1_sg);
    end
  end

  // sum stage: matrix entries, or the yaw word and operands of the pitch and roll vectors
  erc_pkg::op_t         s_op;
  logic [8:0][W-1:0]    s_r;
  logic signed [VW-1:0] s_x [2];
  logic signed [VW-1:0] s_y [2];

  always_ff @(posedge clk) begin
    if (en) begin
      s_op <= m2_op;
      if (m2_op == erc_pkg::OP_TO_MATRIX) begin
        s_r[0] <= sat(VW'(m2_p[0]));
        s_r[1] <= sat(VW'(m2_t[0]) - VW'(m2_p[2]));
        s_r[2] <= sat(VW'(m2_p[3]) + VW'(m2_t[1]));
        s_r[3] <= sat(VW'(m2_p[5]));
        s_r[4] <= sat(VW'(m2_t[2]) + VW'(m2_p[4]));
        s_r[5] <= sat(VW'(m2_t[3]) - VW'(m2_p[1]));
        s_r[6] <= sat(-VW'(m2_sb));
        s_r[7] <= sat(VW'(m2_p[8]));
        s_r[8] <= sat(VW'(m2_p[9]));
      end else begin
        s_r <= {{(6*W){1'b0}}, m2_yaw, {(2*W){1'b0}}};
      end
      s_x[0] <= VW'(m2_p[0]) + VW'(m2_p[1]);
      s_y[0] <= m2_ne6;
      s_x[1] <= VW'(m2_p[4]) - VW'(m2_p[5]);
      s_y[1] <= VW'(m2_p[2]) - VW'(m2_p[3]);
    end
  end

  assign vsx[1] = s_x[0];
  assign vsy[1] = s_y[0];
  assign vsx[2] = s_x[1];
  assign vsy[2] = s_y[1];

  sbc_t sbc [NV];

  always_ff @(posedge clk) begin
    if (en) begin
      sbc[0].op <= s_op;
      sbc[0].r  <= s_r;
      for (int k = 1; k < NV; k++) begin
        sbc[k] <= sbc[k-1];
      end
    end
  end

  // output register
  erc_pkg::op_t      out_op;
  logic [8:0][W-1:0] res;

  always_ff @(posedge clk) begin
    if (en) begin
      out_op <= sbc[NV-1].op;
      if (sbc[NV-1].op == erc_pkg::OP_TO_MATRIX) begin
        res <= sbc[NV-1].r;
      end else begin
        res <= {{(6*W){1'b0}}, sbc[NV-1].r[2], vang[1], vang[2]};
      end
    end
  end

  assign result_0 = $signed(res[0]);
  assign result_1 = $signed(res[1]);
  assign result_2 = $signed(res[2]);
  assign result_3 = $signed(res[3]);
  assign result_4 = $signed(res[4]);
  assign result_5 = $signed(res[5]);
  assign result_6 = $signed(res[6]);
  assign result_7 = $signed(res[7]);
  assign result_8 = $signed(res[8]);

`ifndef ASSERT_OFF
  a_angles_zero_fill: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_op == erc_pkg::OP_TO_ANGLES |->
      result_3 == '0 && result_4 == '0 && result_5 == '0 &&
      result_6 == '0 && result_7 == '0 && result_8 == '0)
    else $error("angle word carries nonzero matrix fields");

  a_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid bits moved during a stall");
`endif

endmodule
